>>> src/ktinterp_pkg.sv
// ----------------------------------------------------------------------------
// ktinterp_pkg: shared types and constants for the keyframe interpolator
// Field widths, register indexes, curve codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none
package ktinterp_pkg;

  localparam int FRAME_W     = 16;
  localparam int VAL_W       = 16;
  localparam int CURVE_W     = 3;
  localparam int SUB_W       = 12;
  localparam int IDX_W       = 6;
  localparam int KCNT_W      = 7;
  localparam int T_W         = 13;
  localparam int NUM_W       = FRAME_W + SUB_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MAX_KEYS_DEF = 64;

  localparam logic [T_W-1:0] ONE_Q12 = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_WRAP = 3'd4;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  // curve codes
  localparam logic [CURVE_W-1:0] CURVE_LINEAR   = 3'd0;
  localparam logic [CURVE_W-1:0] CURVE_STEP     = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_EASE_IN  = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_EASE_OUT = 3'd3;
  localparam logic [CURVE_W-1:0] CURVE_EASE_IO  = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic       mem_wr;
    logic       cap;
    logic       rd;
    logic       save_prv;
    logic       ld_before;
    logic       ld_interp;
    logic       hold_ent;
    logic       hold_prv;
    logic       ld_zero;
    logic       div_step;
    logic       shp1;
    logic       shp2;
    logic       shp3;
    logic       bl_mul;
    logic       bl_acc;
    logic       ld_out;
    logic [1:0] chan;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic lt_ent;
    logic at_ent;
    logic past_ent;
    logic le_ent;
    logic span_zero;
    logic div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> src/ktinterp_dp.sv
// ----------------------------------------------------------------------------
// ktinterp_dp: keyframe interpolator datapath
// Key table, config registers, compares, restoring divider, shared multiplier,
// curve shaping and channel blend.
// ----------------------------------------------------------------------------
`default_nettype none
module ktinterp_dp #(
  parameter int MAX_KEYS = ktinterp_pkg::MAX_KEYS_DEF,
  localparam int IW = $clog2(MAX_KEYS),
  localparam int CW = $clog2(MAX_KEYS + 1)
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_we_i,
  input  wire  [ktinterp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [ktinterp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire  [ktinterp_pkg::IDX_W-1:0]           key_index_i,
  input  wire  [ktinterp_pkg::FRAME_W-1:0]         key_frame_i,
  input  wire  signed [ktinterp_pkg::VAL_W-1:0]    key_value_x_i,
  input  wire  signed [ktinterp_pkg::VAL_W-1:0]    key_value_y_i,
  input  wire  signed [ktinterp_pkg::VAL_W-1:0]    key_value_z_i,
  input  wire  [ktinterp_pkg::CURVE_W-1:0]         key_curve_i,
  input  wire  [ktinterp_pkg::FRAME_W-1:0]         query_frame_i,
  input  wire  [ktinterp_pkg::SUB_W-1:0]           query_subframe_i,
  input  ktinterp_pkg::dp_cmd_t                    cmd_i,
  input  wire  [IW-1:0]                            rd_addr_i,
  output ktinterp_pkg::dp_stat_t                   stat_o,
  output logic [CW-1:0]                            count_o,
  output logic signed [ktinterp_pkg::VAL_W-1:0]    out_x_o,
  output logic signed [ktinterp_pkg::VAL_W-1:0]    out_y_o,
  output logic signed [ktinterp_pkg::VAL_W-1:0]    out_z_o
);
  import ktinterp_pkg::*;

  localparam int ENT_W = FRAME_W + 3 * VAL_W + CURVE_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  // configuration
  logic [KCNT_W-1:0]        key_count_q;
  logic [2:0][VAL_W-1:0]    start_q;
  logic                     wrap_q;

  // table and read register
  logic [ENT_W-1:0]         mem_q [MAX_KEYS];
  logic [FRAME_W-1:0]       ent_frame_q, prv_frame_q;
  logic [2:0][VAL_W-1:0]    ent_val_q, prv_val_q;
  logic [CURVE_W-1:0]       ent_curve_q;

  // query and working registers
  logic [FRAME_W-1:0]       frame_q;
  logic [SUB_W-1:0]         sub_q;
  logic [2:0][VAL_W-1:0]    from_q, to_q, res_q;
  logic [CURVE_W-1:0]       curve_q;
  logic [NUM_W-1:0]         num_q, quo_q;
  logic [FRAME_W-1:0]       den_q, rem_q;
  logic [DIV_CNT_W-1:0]     dcnt_q;
  logic [T_W-1:0]           t_q;
  logic [25:0]              sq_q;
  logic signed [41:0]       prod_q;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      start_q     <= '0;
      wrap_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_COUNT:  key_count_q <= cfg_data_i[KCNT_W-1:0];
        CFG_START_X:    start_q[0]  <= cfg_data_i;
        CFG_START_Y:    start_q[1]  <= cfg_data_i;
        CFG_START_Z:    start_q[2]  <= cfg_data_i;
        CFG_ANGLE_WRAP: wrap_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturate count to table depth
  assign count_o = (32'(key_count_q) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count_q);

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && (32'(key_index_i) < MAX_KEYS)) begin
      mem_q[IW'(key_index_i)] <= {key_curve_i, key_value_z_i, key_value_y_i,
                                  key_value_x_i, key_frame_i};
    end
    if (cmd_i.rd) begin
      {ent_curve_q, ent_val_q, ent_frame_q} <= mem_q[rd_addr_i];
    end
  end

  // compare query against current entry
  always_comb begin
    stat_o.lt_ent    = frame_q < ent_frame_q;
    stat_o.at_ent    = (frame_q == ent_frame_q) && (sub_q == '0);
    stat_o.past_ent  = (frame_q > ent_frame_q) ||
                       ((frame_q == ent_frame_q) && (sub_q != '0));
    stat_o.le_ent    = ent_frame_q <= frame_q;
    stat_o.span_zero = ent_frame_q == prv_frame_q;
    stat_o.div_last  = dcnt_q == DIV_CNT_W'(NUM_W - 1);
  end

  // divider step
  logic [FRAME_W:0]   rem_sh;
  logic               q_bit;
  logic [FRAME_W-1:0] span;
  logic [FRAME_W-1:0] dfr;
  logic [T_W-1:0]     t_raw;
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    q_bit  = rem_sh >= {1'b0, den_q};
    span   = ent_frame_q - prv_frame_q;
    dfr    = frame_q - prv_frame_q;
    t_raw  = (quo_q > NUM_W'(ONE_Q12)) ? ONE_Q12 : quo_q[T_W-1:0];
  end

  // shared multiplier operand select
  logic signed [26:0] mul_a;
  logic signed [14:0] mul_b;
  logic [VAL_W:0]     delta_raw;
  logic [VAL_W:0]     delta;
  always_comb begin
    delta_raw = {to_q[cmd_i.chan][VAL_W-1], to_q[cmd_i.chan]} -
                {from_q[cmd_i.chan][VAL_W-1], from_q[cmd_i.chan]};
    delta     = wrap_q ? {{6{delta_raw[10]}}, delta_raw[10:0]} : delta_raw;
    mul_a = '0;
    mul_b = '0;
    priority if (cmd_i.shp1) begin
      mul_a = signed'({14'b0, t_raw});
      mul_b = (curve_q == CURVE_EASE_OUT) ? signed'(15'd8192 - {2'b0, t_raw})
                                          : signed'({2'b0, t_raw});
    end else if (cmd_i.shp2) begin
      mul_a = signed'({1'b0, prod_q[25:0]});
      mul_b = signed'({2'b0, t_q});
    end else begin
      mul_a = signed'({{10{delta[VAL_W]}}, delta});
      mul_b = signed'({2'b0, t_q});
    end
  end

  // shaped fraction
  logic [27:0]    tri_sq;
  logic [27:0]    cub2;
  logic [27:0]    eio;
  logic [T_W-1:0] shaped;
  always_comb begin
    tri_sq = 28'(sq_q) + 28'({sq_q, 1'b0});
    cub2   = 28'({prod_q[36:12], 1'b0});
    eio    = tri_sq - cub2;
    unique case (curve_q)
      CURVE_STEP:     shaped = '0;
      CURVE_EASE_IN:  shaped = sq_q[24:12];
      CURVE_EASE_OUT: shaped = sq_q[24:12];
      CURVE_EASE_IO:  shaped = eio[24:12];
      default:        shaped = t_q;
    endcase
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      frame_q <= query_frame_i;
      sub_q   <= query_subframe_i;
    end
    if (cmd_i.save_prv) begin
      prv_frame_q <= ent_frame_q;
      prv_val_q   <= ent_val_q;
    end
    // set up blend and divider
    if (cmd_i.ld_before || cmd_i.ld_interp) begin
      from_q  <= cmd_i.ld_before ? start_q : prv_val_q;
      to_q    <= ent_val_q;
      curve_q <= ent_curve_q;
      num_q   <= cmd_i.ld_before ? {frame_q, sub_q} : {dfr, sub_q};
      den_q   <= cmd_i.ld_before ? ent_frame_q : span;
      rem_q   <= '0;
      quo_q   <= '0;
      dcnt_q  <= '0;
    end
    // advance divider one bit
    if (cmd_i.div_step) begin
      rem_q  <= q_bit ? FRAME_W'(rem_sh - {1'b0, den_q}) : rem_sh[FRAME_W-1:0];
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      quo_q  <= {quo_q[NUM_W-2:0], q_bit};
      dcnt_q <= dcnt_q + DIV_CNT_W'(1);
    end
    if (cmd_i.shp1) t_q <= t_raw;
    if (cmd_i.shp2) sq_q <= prod_q[25:0];
    if (cmd_i.shp3) t_q <= shaped;
    if (cmd_i.shp1 || cmd_i.shp2 || cmd_i.bl_mul) prod_q <= mul_a * mul_b;
    // results
    priority if (cmd_i.ld_zero) begin
      res_q <= '0;
    end else if (cmd_i.hold_ent) begin
      res_q <= ent_val_q;
    end else if (cmd_i.hold_prv) begin
      res_q <= prv_val_q;
    end else if (cmd_i.bl_acc) begin
      res_q[cmd_i.chan] <= from_q[cmd_i.chan] + prod_q[27:12];
    end
    if (cmd_i.ld_out) begin
      out_x_o <= res_q[0];
      out_y_o <= res_q[1];
      out_z_o <= res_q[2];
    end
  end

endmodule
`default_nettype wire

>>> src/ktinterp_ctrl.sv
// ----------------------------------------------------------------------------
// ktinterp_ctrl: keyframe interpolator controller
// Sequences table access, key search, division, shaping and blending.
// ----------------------------------------------------------------------------
`default_nettype none
module ktinterp_ctrl #(
  parameter int MAX_KEYS = ktinterp_pkg::MAX_KEYS_DEF,
  localparam int IW = $clog2(MAX_KEYS),
  localparam int CW = $clog2(MAX_KEYS + 1)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire                     req_type_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  input  ktinterp_pkg::dp_stat_t  stat_i,
  input  wire  [CW-1:0]           count_i,
  output ktinterp_pkg::dp_cmd_t   cmd_o,
  output logic [IW-1:0]           rd_addr_o
);
  import ktinterp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK0 = 4'd1;
  localparam logic [3:0] S_CHKL = 4'd2;
  localparam logic [3:0] S_SRCH = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_SH1  = 4'd5;
  localparam logic [3:0] S_SH2  = 4'd6;
  localparam logic [3:0] S_SH3  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] b_q, b_d;
  logic [1:0]    chan_q, chan_d;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] b_nx;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign b_nx        = b_q + CW'(1);

  // next state and commands
  always_comb begin
    state_d     = state_q;
    b_d         = b_q;
    chan_d      = chan_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.chan  = chan_q;
    rd_addr_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          if (req_type_i == REQ_WRITE) begin
            cmd_o.mem_wr = 1'b1;
          end else if (count_i == '0) begin
            cmd_o.ld_zero = 1'b1;
            state_d = S_OUT;
          end else begin
            cmd_o.rd = 1'b1;
            state_d = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        priority if (stat_i.lt_ent) begin
          cmd_o.ld_before = 1'b1;
          state_d = S_DIV;
        end else if (stat_i.at_ent) begin
          cmd_o.hold_ent = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.save_prv = 1'b1;
          cmd_o.rd = 1'b1;
          rd_addr_o = IW'(count_i - CW'(1));
          state_d = S_CHKL;
        end
      end
      S_CHKL: begin
        if (stat_i.past_ent) begin
          cmd_o.hold_ent = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.rd = 1'b1;
          rd_addr_o = IW'(1);
          b_d = CW'(1);
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        // walk forward while the key is not later than the query
        if (stat_i.le_ent) begin
          cmd_o.save_prv = 1'b1;
          if (b_nx >= count_i) begin
            cmd_o.hold_ent = 1'b1;
            state_d = S_OUT;
          end else begin
            cmd_o.rd = 1'b1;
            rd_addr_o = b_nx[IW-1:0];
            b_d = b_nx;
          end
        end else if (stat_i.span_zero) begin
          cmd_o.hold_prv = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.ld_interp = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_SH1;
      end
      S_SH1: begin
        cmd_o.shp1 = 1'b1;
        state_d = S_SH2;
      end
      S_SH2: begin
        cmd_o.shp2 = 1'b1;
        state_d = S_SH3;
      end
      S_SH3: begin
        cmd_o.shp3 = 1'b1;
        chan_d = 2'd0;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.bl_mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.bl_acc = 1'b1;
        if (chan_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          chan_d = chan_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        // hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      b_q         <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      b_q         <= b_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_div_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !stat_i.div_last) |=> state_q == S_DIV)
    else $error("divider left early");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");
  a_srch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> (b_q < count_i && b_q != '0))
    else $error("search index out of range");
`endif

endmodule
`default_nettype wire

>>> src/keyframe_track_interpolator_top.sv
// Sequence: a write stores the key from idle; an evaluation returns zero on an empty table,
// interpolates from the start values before the first key, holds a key at the first key or
// past the last, else walks the keys to hold one or interpolate via the 28-step divider.
// Throughput: one request at a time; the next is accepted on return to idle, which
// waits while the previous result has not been taken.
// Reset: rst_ni async active low clears config and control; table undefined until written.
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_top: keyframe track interpolator
// Key table with search, Q12 fraction by division, easing and 3-channel blend.
// ----------------------------------------------------------------------------
`default_nettype none
module keyframe_track_interpolator_top #(
  parameter int MAX_KEYS = ktinterp_pkg::MAX_KEYS_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire  [ktinterp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [ktinterp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire                                    req_type_i,
  input  wire  [ktinterp_pkg::IDX_W-1:0]         key_index_i,
  input  wire  [ktinterp_pkg::FRAME_W-1:0]       key_frame_i,
  input  wire  signed [ktinterp_pkg::VAL_W-1:0]  key_value_x_i,
  input  wire  signed [ktinterp_pkg::VAL_W-1:0]  key_value_y_i,
  input  wire  signed [ktinterp_pkg::VAL_W-1:0]  key_value_z_i,
  input  wire  [ktinterp_pkg::CURVE_W-1:0]       key_curve_i,
  input  wire  [ktinterp_pkg::FRAME_W-1:0]       query_frame_i,
  input  wire  [ktinterp_pkg::SUB_W-1:0]         query_subframe_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic signed [ktinterp_pkg::VAL_W-1:0]  out_x_o,
  output logic signed [ktinterp_pkg::VAL_W-1:0]  out_y_o,
  output logic signed [ktinterp_pkg::VAL_W-1:0]  out_z_o
);
  import ktinterp_pkg::*;

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] count;

  // sequence requests
  ktinterp_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .count_i     (count),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  // table and arithmetic
  ktinterp_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .key_index_i      (key_index_i),
    .key_frame_i      (key_frame_i),
    .key_value_x_i    (key_value_x_i),
    .key_value_y_i    (key_value_y_i),
    .key_value_z_i    (key_value_z_i),
    .key_curve_i      (key_curve_i),
    .query_frame_i    (query_frame_i),
    .query_subframe_i (query_subframe_i),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .stat_o           (stat),
    .count_o          (count),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_z_o          (out_z_o)
  );

endmodule
`default_nettype wire

>>> sim/keyframe_track_interpolator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_top_tb: self-checking bench for the interpolator
// Loads key tables, sweeps the register settings and evaluates the track
// through random idle and stall patterns. A local model of the key search,
// Q12 fraction, curve shaping and channel blend predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none
module keyframe_track_interpolator_top_tb;
  import ktinterp_pkg::*;

  localparam int NKEYS       = MAX_KEYS_DEF;
  localparam int SETTLE_CYC  = 200;
  localparam int TARGET_REQS = 650;

  typedef enum logic [1:0] {JOB_REQ, JOB_CFG, JOB_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e                  kind;
    int                         gap;
    logic [CFG_IDX_W-1:0]       cidx;
    logic [CFG_DATA_W-1:0]      cdata;
    logic                       rtype;
    logic [IDX_W-1:0]           kidx;
    logic [FRAME_W-1:0]         kframe;
    logic signed [VAL_W-1:0]    kx, ky, kz;
    logic [CURVE_W-1:0]         kcurve;
    logic [FRAME_W-1:0]         qframe;
    logic [SUB_W-1:0]           qsub;
  } job_t;

  typedef struct {
    logic signed [VAL_W-1:0] x, y, z;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = 1'b0;
  logic [IDX_W-1:0] key_index_i = '0;
  logic [FRAME_W-1:0] key_frame_i = '0;
  logic signed [VAL_W-1:0] key_value_x_i = '0, key_value_y_i = '0, key_value_z_i = '0;
  logic [CURVE_W-1:0] key_curve_i = '0;
  logic [FRAME_W-1:0] query_frame_i = '0;
  logic [SUB_W-1:0] query_subframe_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [VAL_W-1:0] out_x_o, out_y_o, out_z_o;

  job_t  pending_jobs[$];
  pose_t expected_poses[$];
  int    fail_count = 0;

  // track model state
  logic [FRAME_W-1:0]      trk_frame[NKEYS];
  logic signed [VAL_W-1:0] trk_x[NKEYS], trk_y[NKEYS], trk_z[NKEYS];
  logic [CURVE_W-1:0]      trk_curve[NKEYS];
  int unsigned             trk_count = 0;
  int                      trk_sx = 0, trk_sy = 0, trk_sz = 0;
  logic                    trk_wrap = 1'b0;

  // generator shadow of the table
  logic [FRAME_W-1:0] gen_frame[NKEYS];
  bit                 gen_written[NKEYS];
  bit                 calm_tx = 0;
  int                 req_total = 0;

  always #4 clk_i = ~clk_i;

  keyframe_track_interpolator_top i_dut (.*);

  // shape a Q12 fraction by a curve code
  function automatic int unsigned curve_shape(int unsigned t, logic [CURVE_W-1:0] mode);
    longint unsigned t2;
    t2 = longint'(t) * t;
    case (mode)
      CURVE_STEP:     return 0;
      CURVE_EASE_IN:  return int'(t2 >> 12);
      CURVE_EASE_OUT: return int'((longint'(t) * (8192 - t)) >> 12);
      CURVE_EASE_IO:  return int'((3 * t2 - 2 * ((t2 * t) >> 12)) >> 12);
      default:        return t;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] blend_chan(int from, int to, int unsigned t);
    int     d;
    longint p;
    int     r;
    d = to - from;
    if (trk_wrap) d = ((d + 1024) & 2047) - 1024;
    p = longint'(d) * longint'(t);
    r = from + int'(p >>> 12);
    return r[VAL_W-1:0];
  endfunction

  function automatic pose_t key_pose(int k);
    pose_t p;
    p.x = trk_x[k]; p.y = trk_y[k]; p.z = trk_z[k];
    return p;
  endfunction

  // evaluate the track at a frame plus subframe
  function automatic pose_t track_eval(int unsigned frame, int unsigned sub);
    pose_t       p;
    int unsigned cnt, f0, fl, b, a, span, raw, t;
    cnt = trk_count > NKEYS ? NKEYS : trk_count;
    p.x = '0; p.y = '0; p.z = '0;
    if (cnt == 0) return p;
    f0 = trk_frame[0];
    if (frame < f0) begin
      raw = (frame * 4096 + sub) / f0;
      if (raw > 4096) raw = 4096;
      t = curve_shape(raw, trk_curve[0]);
      p.x = blend_chan(trk_sx, trk_x[0], t);
      p.y = blend_chan(trk_sy, trk_y[0], t);
      p.z = blend_chan(trk_sz, trk_z[0], t);
      return p;
    end
    if (frame == f0 && sub == 0) return key_pose(0);
    fl = trk_frame[cnt-1];
    if (frame > fl || (frame == fl && sub > 0)) return key_pose(cnt - 1);
    b = 1;
    while (b < cnt && trk_frame[b] <= frame) b++;
    if (b >= cnt) return key_pose(cnt - 1);
    a = b - 1;
    span = (trk_frame[b] - trk_frame[a]) & 16'hFFFF;
    if (span == 0) return key_pose(a);
    raw = (((frame - trk_frame[a]) & 16'hFFFF) * 4096 + sub) / span;
    if (raw > 4096) raw = 4096;
    t = curve_shape(raw, trk_curve[b]);
    p.x = blend_chan(trk_x[a], trk_x[b], t);
    p.y = blend_chan(trk_y[a], trk_y[b], t);
    p.z = blend_chan(trk_z[a], trk_z[b], t);
    return p;
  endfunction

  task automatic push_job(job_t j);
    j.gap = calm_tx ? 0 : $urandom_range(0, 15);
    pending_jobs.push_back(j);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    job_t j;
    j = '{kind: JOB_CFG, default: '0};
    j.cidx = idx; j.cdata = data;
    push_job(j);
  endtask

  task automatic add_key(int k, logic [FRAME_W-1:0] f, logic [VAL_W-1:0] x,
                         logic [VAL_W-1:0] y, logic [VAL_W-1:0] z, logic [CURVE_W-1:0] c);
    job_t j;
    j = '{kind: JOB_REQ, default: '0};
    j.rtype = REQ_WRITE; j.kidx = k[IDX_W-1:0];
    j.kframe = f; j.kx = x; j.ky = y; j.kz = z; j.kcurve = c;
    j.qframe = 16'($urandom); j.qsub = 12'($urandom);
    gen_frame[k] = f; gen_written[k] = 1;
    req_total++;
    push_job(j);
  endtask

  task automatic add_rand_key(int k, logic [FRAME_W-1:0] f);
    add_key(k, f, 16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
  endtask

  task automatic add_query(logic [FRAME_W-1:0] f, logic [SUB_W-1:0] s);
    job_t j;
    j = '{kind: JOB_REQ, default: '0};
    j.rtype = REQ_EVAL; j.qframe = f; j.qsub = s;
    j.kidx = 6'($urandom); j.kframe = 16'($urandom); j.kx = 16'($urandom);
    j.ky = 16'($urandom); j.kz = 16'($urandom); j.kcurve = 3'($urandom);
    req_total++;
    push_job(j);
  endtask

  task automatic add_drain();
    job_t j;
    j = '{kind: JOB_DRAIN, default: '0};
    pending_jobs.push_back(j);
  endtask

  // request driver and register writer
  always @(posedge clk_i) begin
    logic nxt_valid;
    logic nxt_we;
    job_t j;
    static job_t cur;
    static int   gap_left = 0;
    static int   settle = 0;
    nxt_valid = in_valid_i;
    nxt_we = 1'b0;
    if (rst_ni) begin
      // accept: update the model and predict
      if (in_valid_i && in_ready_o) begin
        nxt_valid = 1'b0;
        settle = 0;
        if (cur.rtype == REQ_WRITE) begin
          trk_frame[cur.kidx] = cur.kframe;
          trk_x[cur.kidx] = cur.kx; trk_y[cur.kidx] = cur.ky; trk_z[cur.kidx] = cur.kz;
          trk_curve[cur.kidx] = cur.kcurve;
        end else begin
          expected_poses.push_back(track_eval(cur.qframe, cur.qsub));
        end
      end
      // advance to the next job
      if (!nxt_valid && pending_jobs.size() > 0) begin
        j = pending_jobs[0];
        if (j.kind == JOB_DRAIN) begin
          if (expected_poses.size() == 0) void'(pending_jobs.pop_front());
        end else if (j.kind == JOB_CFG) begin
          if (expected_poses.size() == 0) begin
            if (settle < SETTLE_CYC) settle++;
            else begin
              nxt_we = 1'b1;
              cfg_idx_i <= j.cidx;
              cfg_data_i <= j.cdata;
              case (j.cidx)
                CFG_KEY_COUNT:  trk_count = j.cdata[KCNT_W-1:0];
                CFG_START_X:    trk_sx = $signed(j.cdata);
                CFG_START_Y:    trk_sy = $signed(j.cdata);
                CFG_START_Z:    trk_sz = $signed(j.cdata);
                CFG_ANGLE_WRAP: trk_wrap = j.cdata[0];
                default: ;
              endcase
              void'(pending_jobs.pop_front());
            end
          end
        end else if (gap_left < j.gap) begin
          gap_left++;
        end else begin
          gap_left = 0;
          cur = j;
          nxt_valid = 1'b1;
          req_type_i <= j.rtype;
          key_index_i <= j.kidx;
          key_frame_i <= j.kframe;
          key_value_x_i <= j.kx;
          key_value_y_i <= j.ky;
          key_value_z_i <= j.kz;
          key_curve_i <= j.kcurve;
          query_frame_i <= j.qframe;
          query_subframe_i <= j.qsub;
          void'(pending_jobs.pop_front());
        end
      end
    end
    in_valid_i <= nxt_valid;
    cfg_we_i <= nxt_we;
  end

  // result monitor with random back-pressure
  always @(posedge clk_i) begin
    pose_t exp_p;
    logic  nxt_ready;
    static int stall_left = 0;
    static int rx_count = 0;
    nxt_ready = out_ready_i;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rx_count++;
        if (expected_poses.size() == 0) begin
          $error("unexpected result x=%0d y=%0d z=%0d", out_x_o, out_y_o, out_z_o);
          fail_count++;
        end else begin
          exp_p = expected_poses.pop_front();
          if (out_x_o !== exp_p.x) begin
            $error("out_x expected %0d actual %0d", exp_p.x, out_x_o); fail_count++;
          end
          if (out_y_o !== exp_p.y) begin
            $error("out_y expected %0d actual %0d", exp_p.y, out_y_o); fail_count++;
          end
          if (out_z_o !== exp_p.z) begin
            $error("out_z expected %0d actual %0d", exp_p.z, out_z_o); fail_count++;
          end
        end
        stall_left = ((rx_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 15);
        nxt_ready = (stall_left == 0);
      end else if (!out_ready_i) begin
        if (stall_left > 0) stall_left--;
        nxt_ready = (stall_left == 0);
      end
    end
    out_ready_i <= nxt_ready;
  end

  // stimulus and end of run
  initial begin
    int n, base, step, k, f, r;
    for (int i = 0; i < NKEYS; i++) gen_written[i] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // empty table
    add_query(16'd0, 12'd0);
    add_query(16'hFFFF, 12'hFFF);
    // small sorted table covering each curve code and two undefined codes
    add_key(0, 16'd100, 16'sh7FFF, 16'sh8000, 16'sd0, CURVE_LINEAR);
    add_key(1, 16'd150, 16'sh8000, 16'sh7FFF, 16'sd1000, CURVE_STEP);
    add_key(2, 16'd200, 16'sd500, 16'sd0, -16'sd1000, CURVE_EASE_IN);
    add_key(3, 16'd300, 16'sd2000, 16'sd700, 16'sd3, CURVE_EASE_OUT);
    add_key(4, 16'd400, -16'sd2000, 16'sd10, 16'sd1023, CURVE_EASE_IO);
    add_key(5, 16'd401, 16'sd77, 16'sh7FFF, -16'sd1024, 3'd5);
    add_key(6, 16'd1000, 16'sd0, -16'sd5, 16'sd600, 3'd7);
    add_key(7, 16'hFFFF, 16'sd1, 16'sd2, 16'sd3, CURVE_LINEAR);
    add_cfg(CFG_KEY_COUNT, 16'd8);
    add_cfg(CFG_START_X, 16'h8000);
    add_cfg(CFG_START_Y, 16'h7FFF);
    add_cfg(CFG_START_Z, 16'd0);
    add_query(16'd0, 12'd0);        // before first key
    add_query(16'd99, 12'hFFF);
    add_query(16'd100, 12'd0);      // at first key
    add_query(16'd125, 12'd2048);
    add_query(16'd170, 12'd1);
    add_query(16'd250, 12'd100);
    add_query(16'd350, 12'd3000);
    add_query(16'd400, 12'd2048);
    add_query(16'd700, 12'd5);
    add_query(16'hFFFF, 12'd0);     // exactly at last key
    add_query(16'hFFFF, 12'hFFF);   // past last key
    add_drain();
    add_cfg(CFG_ANGLE_WRAP, 16'd1);
    add_query(16'd125, 12'd1000);
    add_query(16'd40, 12'd7);

    // random phases
    for (int ph = 0; req_total < TARGET_REQS; ph++) begin
      calm_tx = (ph % 4 == 1);
      r = $urandom_range(0, 9);
      if (r == 0) n = 0;
      else if (r == 1) n = 1;
      else if (r == 2) n = NKEYS;
      else if (r == 3) n = $urandom_range(65, 127);
      else n = $urandom_range(2, 12);
      k = n > NKEYS ? NKEYS : n;
      // load a run of keys in nondecreasing frame order until the frame wraps, or fill the gaps only
      if ($urandom_range(0, 1) == 0 || ph == 0) begin
        base = $urandom_range(0, 3000);
        step = (ph % 5 == 0) ? 1000 : $urandom_range(1, 80);
        for (int i = 0; i < k; i++) begin
          f = base + i * $urandom_range(0, step);
          base = f - i * 0;
          add_rand_key(i, 16'(f));
        end
      end else begin
        for (int i = 0; i < k; i++) if (!gen_written[i]) add_rand_key(i, 16'($urandom));
      end
      add_cfg(CFG_KEY_COUNT, 16'(n));
      add_cfg(CFG_ANGLE_WRAP, 16'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0: add_cfg(CFG_START_X, 16'h8000);
        1: add_cfg(CFG_START_X, 16'h7FFF);
        default: add_cfg(CFG_START_X, 16'($urandom));
      endcase
      add_cfg(CFG_START_Y, 16'($urandom));
      add_cfg(CFG_START_Z, 16'($urandom));
      for (int i = 0; i < 45; i++) begin
        r = $urandom_range(0, 99);
        if (i == 20 && ph % 3 == 0) add_drain();
        if (r < 10) begin
          // overwrite one entry, possibly out of order
          f = $urandom_range(0, NKEYS - 1);
          if (!gen_written[f]) f = 0;
          if (gen_written[f]) add_rand_key(f, (r < 5) ? 16'($urandom)
                                              : 16'(gen_frame[f] + $urandom_range(0, 40)));
        end else if (r < 16 || k == 0) begin
          add_query(16'($urandom), 12'($urandom));
        end else begin
          f = gen_frame[$urandom_range(0, k - 1)] + $urandom_range(0, 60) - 20;
          add_query(16'(f), ($urandom_range(0, 4) == 0) ? 12'd0 : 12'($urandom));
        end
      end
    end

    // wait for everything to drain
    while (pending_jobs.size() > 0 || in_valid_i || expected_poses.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (fail_count == 0 && expected_poses.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
